/* hw/rtl/sha512_pkg.sv */
`timescale 1ns / 1ps
package sha512_pkg;

	typedef struct packed {
		logic [63:0] msg_word;
		logic [3:0]  byte_count;
		logic        final_word;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic        digest_last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD,
		ST_ADD,
		ST_OUT
	} state_t;

	localparam logic [63:0] PAD_WORD = 64'h8000000000000000;

	function automatic logic [63:0] init_value(input logic [2:0] i);
		logic [63:0] r;
		case (i)
			3'd0: r = 64'h6a09e667f3bcc908;
			3'd1: r = 64'hbb67ae8584caa73b;
			3'd2: r = 64'h3c6ef372fe94f82b;
			3'd3: r = 64'ha54ff53a5f1d36f1;
			3'd4: r = 64'h510e527fade682d1;
			3'd5: r = 64'h9b05688c2b3e6c1f;
			3'd6: r = 64'h1f83d9abfb41bd6b;
			default: r = 64'h5be0cd19137e2179;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] round_k(input logic [6:0] r);
		logic [63:0] k;
		case (r)
			7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
			7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
			7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
			7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
			7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec; default: k = 64'h6c44198c4a475817;
		endcase
		return k;
	endfunction

endpackage

/* hw/rtl/sha512_round.sv */
`timescale 1ns / 1ps
module sha512_round import sha512_pkg::*; (
	input  logic [511:0] v_in,
	input  logic [63:0]  w,
	input  logic [63:0]  k,
	output logic [511:0] v_out
);
	logic [63:0] a, b, c, d, e, f, g, h, t1, t2;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	always_comb begin
		{a, b, c, d, e, f, g, h} = v_in;
		t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g)) + k + w;
		t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
		v_out = {t1 + t2, a, b, c, d + t1, e, f, g};
	end
endmodule

/* hw/rtl/sha512_hash_engine.sv */
`timescale 1ns / 1ps
// channel | signals                    | payload
// in      | in_valid / in_ready        | in_item_t  (msg_word, byte_count, final_word)
// out     | out_valid / out_ready      | out_item_t (digest_word, digest_last)
// A non-final word is taken in ST_IDLE; the 16th word of a block starts the 80 rounds,
// one round per cycle through the shared round unit, then the chain update in ST_ADD.
// A final word costs one or two such compressions, each but one that starts right at
// a full block preceded by a padding step in ST_PAD, plus 8 output transactions.
// in_ready is low outside ST_IDLE; out side stalls hold the word.
// Reset loads the initial hash value and clears length and position.
module sha512_hash_engine import sha512_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	state_t state_q, state_d;
	logic [63:0]  blk_q [16];
	logic [511:0] h_q, v_q, v_nxt;
	logic [3:0]   pos_q;
	logic [127:0] len_q;
	logic [6:0]   rnd_q;
	logic [2:0]   oidx_q;
	logic         fin_q, extra_q, mark_q;
	logic [63:0]  w_cur, w_new, x1, x14, s0, s1, pad_w;
	logic [3:0]   nb;
	logic [6:0]   shamt;
	logic         acc;
	logic         pad_fits;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	assign acc = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data.digest_word = h_q[511:448];
	assign out_data.digest_last = (oidx_q == 3'd7);

	always_comb begin
		nb = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
		shamt = 7'(7'd64 - {nb, 3'b000});
		pad_w = (in_data.msg_word & (~64'd0 << shamt)) | (PAD_WORD >> {nb, 3'b000});
		x1 = blk_q[4'(rnd_q[3:0] + 4'd1)];
		x14 = blk_q[4'(rnd_q[3:0] + 4'd14)];
		s0 = rotr(x1, 1) ^ rotr(x1, 8) ^ (x1 >> 7);
		s1 = rotr(x14, 19) ^ rotr(x14, 61) ^ (x14 >> 6);
		w_new = blk_q[rnd_q[3:0]] + s1 + blk_q[4'(rnd_q[3:0] + 4'd9)] + s0;
		w_cur = (rnd_q < 7'd16) ? blk_q[rnd_q[3:0]] : w_new;
		// marker (if owed) plus the two length words must fit in this block
		pad_fits = extra_q ? (pos_q <= 4'd13) : (pos_q <= 4'd14);
	end

	sha512_round u_round (.v_in(v_q), .w(w_cur), .k(round_k(rnd_q)), .v_out(v_nxt));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc) begin
				if (!in_data.final_word)
					state_d = (pos_q == 4'd15) ? ST_COMP : ST_IDLE;
				else
					state_d = (pos_q == 4'd15) ? ST_COMP : ST_PAD;
			end
			ST_PAD: state_d = ST_COMP;
			ST_COMP: if (rnd_q == 7'd79) state_d = ST_ADD;
			ST_ADD: state_d = (fin_q && !extra_q) ? ST_OUT :
				(fin_q ? ST_PAD : ST_IDLE);
			ST_OUT: if (out_ready && oidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			len_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			fin_q <= 1'b0;
			extra_q <= 1'b0;
			mark_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[511 - 64*i -: 64] <= init_value(3'(i));
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: if (acc) begin
					v_q <= h_q;
					rnd_q <= '0;
					pos_q <= pos_q + 4'd1;
					if (!in_data.final_word) begin
						len_q <= len_q + 128'd64;
						blk_q[pos_q] <= in_data.msg_word;
					end else begin
						fin_q <= 1'b1;
						len_q <= len_q + 128'({nb, 3'b000});
						blk_q[pos_q] <= (nb == 4'd8) ? in_data.msg_word : pad_w;
						// full word: marker still owed; last slot: a second block follows
						extra_q <= (nb == 4'd8) || (pos_q == 4'd15);
						mark_q <= (nb == 4'd8) && (pos_q == 4'd15);
					end
				end
				ST_PAD: begin
					// extra_q here: marker still owed at pos_q
					v_q <= h_q;
					rnd_q <= '0;
					for (int i = 0; i < 16; i++) begin
						if (pad_fits && i == 14) blk_q[i] <= len_q[127:64];
						else if (pad_fits && i == 15) blk_q[i] <= len_q[63:0];
						else if (extra_q && 4'(i) == pos_q) blk_q[i] <= PAD_WORD;
						else if (4'(i) >= pos_q) blk_q[i] <= '0;
					end
					// length does not fit: compress this block, then a length-only one
					extra_q <= !pad_fits;
					pos_q <= '0;
				end
				ST_COMP: begin
					v_q <= v_nxt;
					if (rnd_q >= 7'd16) blk_q[rnd_q[3:0]] <= w_new;
					rnd_q <= rnd_q + 7'd1;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++)
						h_q[511 - 64*i -: 64] <= h_q[511 - 64*i -: 64] + v_q[511 - 64*i -: 64];
					if (!fin_q) pos_q <= '0;
					oidx_q <= '0;
					// a pending second block: ST_PAD sees pos 0, marker owed only if mark_q
					if (fin_q && extra_q) begin
						extra_q <= mark_q;
						mark_q <= 1'b0;
					end
				end
				ST_OUT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) h_q[511 - 64*i -: 64] <= init_value(3'(i));
						len_q <= '0;
						pos_q <= '0;
						fin_q <= 1'b0;
						extra_q <= 1'b0;
						mark_q <= 1'b0;
					end else begin
						h_q <= {h_q[447:0], 64'd0};
					end
				end
				default: ;
			endcase
		end
	end
endmodule

/* test/sha512_hash_engine_tb.sv */
`timescale 1ns / 1ps
module sha512_hash_engine_tb;
	import sha512_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	sha512_hash_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// predictor state
	logic [63:0]  hash_state [8];
	logic [63:0]  msg_block [16];
	int unsigned  blk_pos;
	logic [127:0] msg_bits;

	out_item_t    digest_q [$];
	int           mismatches;
	int           cycles;
	bit           stim_done;

	localparam logic [63:0] K_TAB [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};
	localparam logic [63:0] IV_TAB [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	function automatic logic [63:0] ror(logic [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic compress();
		logic [63:0] w [16];
		logic [63:0] v [8];
		logic [63:0] t1, t2, x1, x14;
		for (int i = 0; i < 16; i++) w[i] = msg_block[i];
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16) begin
				x1 = w[(r + 1) & 15];
				x14 = w[(r + 14) & 15];
				w[r & 15] += (ror(x14, 19) ^ ror(x14, 61) ^ (x14 >> 6)) + w[(r + 9) & 15]
					+ (ror(x1, 1) ^ ror(x1, 8) ^ (x1 >> 7));
			end
			t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r & 15];
			t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--) v[i] = v[i - 1];
			v[4] += t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endtask

	task automatic store_word(logic [63:0] w);
		msg_block[blk_pos] = w;
		blk_pos = (blk_pos + 1) & 15;
		if (blk_pos == 0) compress();
	endtask

	task automatic clear_hash();
		for (int i = 0; i < 8; i++) hash_state[i] = IV_TAB[i];
		blk_pos = 0;
		msg_bits = '0;
	endtask

	task automatic predict_item(in_item_t it);
		logic [63:0] w;
		int unsigned nb;
		out_item_t o;
		w = it.msg_word;
		if (!it.final_word) begin
			msg_bits += 128'd64;
			store_word(w);
			return;
		end
		nb = (it.byte_count > 8) ? 8 : it.byte_count;
		msg_bits += 128'(nb * 8);
		if (nb == 8) begin
			store_word(w);
			w = PAD_WORD;
		end else if (nb == 0) begin
			w = PAD_WORD;
		end else begin
			w &= ~64'd0 << (64 - 8 * nb);
			w |= 64'h80 << (56 - 8 * nb);
		end
		msg_block[blk_pos] = w;
		blk_pos++;
		if (blk_pos > 14) begin
			while (blk_pos < 16) begin
				msg_block[blk_pos] = '0;
				blk_pos++;
			end
			compress();
			blk_pos = 0;
		end
		while (blk_pos < 14) begin
			msg_block[blk_pos] = '0;
			blk_pos++;
		end
		msg_block[14] = msg_bits[127:64];
		msg_block[15] = msg_bits[63:0];
		compress();
		for (int i = 0; i < 8; i++) begin
			o.digest_word = hash_state[i];
			o.digest_last = (i == 7);
			digest_q.push_back(o);
		end
		clear_hash();
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: stall on an LFSR pattern, periodically open for long stretches
	logic [15:0] stall_pat;
	always @(negedge clk) begin
		if (cycles % 300 < 100) out_ready <= 1'b1;
		else begin
			stall_pat = {stall_pat[14:0], stall_pat[15] ^ stall_pat[13] ^ stall_pat[12]
				^ stall_pat[10]};
			out_ready <= stall_pat[0] | stall_pat[3];
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				report("unexpected digest word", out_data.digest_word, '0);
			end else begin
				if (out_data.digest_word !== digest_q[0].digest_word)
					report("digest_word", out_data.digest_word, digest_q[0].digest_word);
				if (out_data.digest_last !== digest_q[0].digest_last)
					report("digest_last", 64'(out_data.digest_last),
						64'(digest_q[0].digest_last));
				void'(digest_q.pop_front());
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("sha512_hash_engine_tb failed");
			$finish;
		end
	end

	int burst_left;

	// valid stays up between back-to-back transactions; it drops only in a gap
	task automatic send_word(in_item_t it);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(it);
		burst_left--;
		@(negedge clk);
	endtask

	function automatic in_item_t mk(logic [63:0] w, logic [3:0] n, logic f);
		in_item_t it;
		it.msg_word = w;
		it.byte_count = n;
		it.final_word = f;
		return it;
	endfunction

	in_item_t directed [$];
	logic [63:0] abc_digest [8];
	in_item_t it;
	int n_rand, len;

	initial begin
		mismatches = 0;
		cycles = 0;
		stim_done = 0;
		burst_left = 0;
		stall_pat = 16'hACE1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		clear_hash();
		for (int i = 0; i < 16; i++) msg_block[i] = '0;

		// "abc" known digest checks the predictor too
		abc_digest = '{64'hddaf35a193617aba, 64'hcc417349ae204131, 64'h12e6fa4e89a97ea2,
			64'h0a9eeee64b55d39a, 64'h2192992a274fc1a8, 64'h36ba3c23a3feebbd,
			64'h454d4423643ce80e, 64'h2a9ac94fa54ca49f};

		// empty message, "abc", full final word, saturated count, all-ones, all-zeros
		directed = '{mk(64'h0, 4'd0, 1'b1),
			mk(64'h616263ffffffffff, 4'd3, 1'b1),
			mk(64'hffffffffffffffff, 4'd8, 1'b1),
			mk(64'h0123456789abcdef, 4'd15, 1'b1),
			mk(64'hffffffffffffffff, 4'd15, 1'b0),
			mk(64'hffffffffffffffff, 4'd7, 1'b1),
			mk(64'h0, 4'd1, 1'b1)};
		// 14 words then two bytes: padding spills into a second block
		for (int i = 0; i < 14; i++) directed.push_back(mk({$urandom, $urandom}, 4'd8, 1'b0));
		directed.push_back(mk(64'h5a5a5a5a5a5a5a5a, 4'd2, 1'b1));
		// 15 words then a full final word: it closes the block, marker opens the next
		for (int i = 0; i < 15; i++) directed.push_back(mk({$urandom, $urandom}, 4'd8, 1'b0));
		directed.push_back(mk(64'hc3c3c3c3c3c3c3c3, 4'd8, 1'b1));
		// 15 words then a partial final word in the last slot
		for (int i = 0; i < 15; i++) directed.push_back(mk({$urandom, $urandom}, 4'd8, 1'b0));
		directed.push_back(mk(64'h3c3c3c3c3c3c3c3c, 4'd3, 1'b1));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			send_word(directed[i]);
			if (i == 1) begin
				for (int k = 0; k < 8; k++)
					if (digest_q[k].digest_word !== abc_digest[k])
						report("abc predictor", digest_q[k].digest_word, abc_digest[k]);
			end
		end

		// random messages, mostly short, some crossing block boundaries
		n_rand = 0;
		while (n_rand < 40) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 34) : $urandom_range(0, 6);
			for (int i = 0; i < len; i++) begin
				it = mk({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
				send_word(it);
				n_rand++;
			end
			it = mk({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
			send_word(it);
			n_rand++;
		end
		in_valid <= 1'b0;

		while (digest_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0) $display("sha512_hash_engine_tb passed");
		else $display("sha512_hash_engine_tb failed");
		$finish;
	end

endmodule

/* sha512_hash_engine.f */
hw/rtl/sha512_pkg.sv
hw/rtl/sha512_round.sv
hw/rtl/sha512_hash_engine.sv
test/sha512_hash_engine_tb.sv
